@@ hdl/raster_rect_fill_engine_top_macros.svh @@
// Assertion macros shared by the checker of raster_rect_fill_engine_top.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef RASTER_RECT_FILL_ENGINE_TOP_MACROS_SVH
`define RASTER_RECT_FILL_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, off during reset.
`define RRFE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off during reset.
`define RRFE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/rrfe_pkg.sv @@
// Shared types and constants for the raster rectangle fill engine.
// No dependencies; used by the interfaces, the RAM user and the top level.
`default_nettype none

package rrfe_pkg;

  localparam int FuncW  = 3;
  localparam int CoordW = 9;
  localparam int ColorW = 8;

  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 9;

  localparam int DEF_MAX_COLUMNS = 256;
  localparam int DEF_MAX_ROWS    = 256;

  localparam logic [ColorW-1:0] CLEAR_COLOR = 8'h4F;
  localparam logic [CfgDataW-1:0] AREA_RESET = 9'd256;

  typedef enum logic [FuncW-1:0] {
    FUNC_CLEAR = 3'd0,
    FUNC_PIXEL = 3'd1,
    FUNC_VLINE = 3'd2,
    FUNC_HLINE = 3'd3,
    FUNC_RECT  = 3'd4,
    FUNC_READ  = 3'd5
  } func_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACTIVE_COLUMNS = 1'd0,
    CFG_ACTIVE_ROWS    = 1'd1
  } cfg_idx_t;

endpackage

`default_nettype wire

@@ hdl/rrfe_cmd_if.sv @@
// Command channel: valid/ready handshake carrying one drawing command.
// Depends on rrfe_pkg for field widths.
`default_nettype none

interface rrfe_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [rrfe_pkg::FuncW-1:0]    func;
  logic [rrfe_pkg::CoordW-1:0]   x_first;
  logic [rrfe_pkg::CoordW-1:0]   x_second;
  logic [rrfe_pkg::CoordW-1:0]   y_first;
  logic [rrfe_pkg::CoordW-1:0]   y_second;
  logic [rrfe_pkg::ColorW-1:0]   color;

  modport source (output valid, func, x_first, x_second, y_first, y_second, color,
                  input ready);
  modport sink   (input valid, func, x_first, x_second, y_first, y_second, color,
                  output ready);
endinterface

`default_nettype wire

@@ hdl/rrfe_rsp_if.sv @@
// Response channel: valid/ready handshake carrying one pixel read result.
// Depends on rrfe_pkg for field widths.
`default_nettype none

interface rrfe_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [rrfe_pkg::ColorW-1:0]   pixel_value;
  logic                          pixel_inside;

  modport source (output valid, pixel_value, pixel_inside, input ready);
  modport sink   (input valid, pixel_value, pixel_inside, output ready);
endinterface

`default_nettype wire

@@ hdl/rrfe_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module rrfe_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/raster_rect_fill_engine_top.sv @@
// Raster rectangle fill engine: pixel store with clipped line/rect fill and pixel read.
// Draw commands write one pixel per cycle through the single RAM write port. A read
// passes S_SETUP, S_READ and S_RESP before its result is registered; S_RESP waits while
// an earlier result is unaccepted. The block takes the next command once back in idle.
// Synchronous reset returns to idle, drops any pending result and sets both area
// registers to 256; the pixel store is not cleared and holds garbage until drawn.
`default_nettype none

module raster_rect_fill_engine_top #(
  parameter int MAX_COLUMNS = rrfe_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = rrfe_pkg::DEF_MAX_ROWS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [rrfe_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [rrfe_pkg::CfgDataW-1:0] cfg_data,
  rrfe_cmd_if.sink                           cmd,
  rrfe_rsp_if.source                         rsp
);
  import rrfe_pkg::*;

  localparam int ColAddrW = $clog2(MAX_COLUMNS);
  localparam int RowAddrW = $clog2(MAX_ROWS);
  localparam int RamDepth = 2 ** (ColAddrW + RowAddrW);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_FILL,
    S_READ,
    S_RESP
  } state_t;

  state_t state;

  logic [CfgDataW-1:0] active_columns;
  logic [CfgDataW-1:0] active_rows;
  logic [CoordW-1:0]   area_cols;
  logic [CoordW-1:0]   area_rows;

  logic                is_read;
  logic                is_fill;
  logic [CoordW-1:0]   xa, xb, ya, yb;
  logic [CoordW-1:0]   x, y;
  logic [ColorW-1:0]   color_r;
  logic                inside_r;

  logic                rsp_valid;
  logic [ColorW-1:0]   rsp_value;
  logic                rsp_inside;

  logic [CoordW-1:0]   x2_sel, y2_sel;
  logic [CoordW-1:0]   xl_clip, xh_clip, yl_clip, yh_clip;
  logic                read_inside;

  logic                ram_we;
  logic [ColAddrW+RowAddrW-1:0] ram_waddr, ram_raddr;
  logic [ColorW-1:0]   ram_rdata;

  // Area saturates at the store size.
  assign area_cols = (32'(active_columns) > MAX_COLUMNS) ? CoordW'(MAX_COLUMNS)
                                                         : active_columns;
  assign area_rows = (32'(active_rows) > MAX_ROWS) ? CoordW'(MAX_ROWS) : active_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_columns <= AREA_RESET;
      active_rows    <= AREA_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACTIVE_COLUMNS: active_columns <= cfg_data;
        CFG_ACTIVE_ROWS:    active_rows    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pick the second corner each command uses.
  always_comb begin
    case (cmd.func)
      FUNC_PIXEL, FUNC_READ: begin
        x2_sel = cmd.x_first;
        y2_sel = cmd.y_first;
      end
      FUNC_VLINE: begin
        x2_sel = cmd.x_first;
        y2_sel = cmd.y_second;
      end
      FUNC_HLINE: begin
        x2_sel = cmd.x_second;
        y2_sel = cmd.y_first;
      end
      default: begin
        x2_sel = cmd.x_second;
        y2_sel = cmd.y_second;
      end
    endcase
  end

  // Clip the ordered box to the area; coordinate zero lies outside.
  assign xl_clip = (xa == '0) ? CoordW'(1) : xa;
  assign yl_clip = (ya == '0) ? CoordW'(1) : ya;
  assign xh_clip = (xb > area_cols) ? area_cols : xb;
  assign yh_clip = (yb > area_rows) ? area_rows : yb;

  assign read_inside = (xa != '0) && (ya != '0) && (xa <= area_cols) && (ya <= area_rows);

  assign cmd.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      // Drop a transferred result unless a new one loads this cycle.
      if (rsp_valid && rsp.ready && (state != S_RESP)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            state   <= S_SETUP;
            is_read <= (cmd.func == FUNC_READ);
            is_fill <= (cmd.func == FUNC_CLEAR) || (cmd.func == FUNC_PIXEL) ||
                       (cmd.func == FUNC_VLINE) || (cmd.func == FUNC_HLINE) ||
                       (cmd.func == FUNC_RECT);
            if (cmd.func == FUNC_CLEAR) begin
              xa      <= CoordW'(1);
              xb      <= area_cols;
              ya      <= CoordW'(1);
              yb      <= area_rows;
              color_r <= CLEAR_COLOR;
            end else begin
              xa      <= (cmd.x_first < x2_sel) ? cmd.x_first : x2_sel;
              xb      <= (cmd.x_first < x2_sel) ? x2_sel : cmd.x_first;
              ya      <= (cmd.y_first < y2_sel) ? cmd.y_first : y2_sel;
              yb      <= (cmd.y_first < y2_sel) ? y2_sel : cmd.y_first;
              color_r <= cmd.color;
            end
          end
        end
        S_SETUP: begin
          if (is_read) begin
            inside_r <= read_inside;
            state    <= S_READ;
          end else if (is_fill && (xl_clip <= xh_clip) && (yl_clip <= yh_clip)) begin
            xa    <= xl_clip;
            xb    <= xh_clip;
            yb    <= yh_clip;
            x     <= xl_clip;
            y     <= yl_clip;
            state <= S_FILL;
          end else begin
            state <= S_IDLE;
          end
        end
        S_FILL: begin
          // Raster scan: advance column, wrap to next row at the right edge.
          if (x == xb) begin
            x <= xa;
            if (y == yb) begin
              state <= S_IDLE;
            end else begin
              y <= y + CoordW'(1);
            end
          end else begin
            x <= x + CoordW'(1);
          end
        end
        S_READ: begin
          state <= S_RESP;
        end
        S_RESP: begin
          // Hold until the output register is free.
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            rsp_value  <= inside_r ? ram_rdata : '0;
            rsp_inside <= inside_r;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign ram_we    = (state == S_FILL);
  assign ram_waddr = {RowAddrW'(y - CoordW'(1)), ColAddrW'(x - CoordW'(1))};
  assign ram_raddr = {RowAddrW'(ya - CoordW'(1)), ColAddrW'(xa - CoordW'(1))};

  rrfe_ram #(
    .Width (ColorW),
    .Depth (RamDepth)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (color_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rsp.valid        = rsp_valid;
  assign rsp.pixel_value  = rsp_value;
  assign rsp.pixel_inside = rsp_inside;

endmodule

`default_nettype wire

@@ hdl/rrfe_checker.sv @@
// Port-level checker for raster_rect_fill_engine_top, attached by bind.
// Depends on rrfe_pkg and raster_rect_fill_engine_top_macros.svh.
`default_nettype none

`include "raster_rect_fill_engine_top_macros.svh"

module rrfe_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        cmd_valid,
  input wire logic                        cmd_ready,
  input wire logic                        rsp_valid,
  input wire logic                        rsp_ready,
  input wire logic [rrfe_pkg::ColorW-1:0] rsp_pixel_value,
  input wire logic                        rsp_pixel_inside
);
  import rrfe_pkg::*;

  // A pending result stays offered.
  `RRFE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

  // A stalled result keeps its payload.
  `RRFE_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready,
                    $stable(rsp_pixel_value) && $stable(rsp_pixel_inside))

  // Outside reads carry a zero colour.
  `RRFE_ASSERT_IMP(a_outside_zero, rsp_valid && !rsp_pixel_inside,
                   rsp_pixel_value == '0)

  // Every command keeps the engine busy for at least the next cycle.
  `RRFE_ASSERT_NEXT(a_busy_after_cmd, cmd_valid && cmd_ready, !cmd_ready)

endmodule

bind raster_rect_fill_engine_top rrfe_checker u_rrfe_checker (
  .clk              (clk),
  .rst              (rst),
  .cmd_valid        (cmd.valid),
  .cmd_ready        (cmd.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_pixel_value  (rsp.pixel_value),
  .rsp_pixel_inside (rsp.pixel_inside)
);

`default_nettype wire
